@@ sv/atfp_pkg.sv @@
// Shared types, constants and the digit weight function for the ASCII tag frame parser.
// No dependencies; imported by every module of the block.
package atfp_pkg;

   localparam int unsigned TAG_W   = 14;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned IDLE_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned DIGIT_W = 4;

   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
   localparam logic [BYTE_W-1:0] ASCII_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] ASCII_CR   = 8'h0D;

   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 16'd100;

   // item kind carried in req_tuser
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_POLL = 1'b1;

   typedef enum logic [2:0] {
      STEP_DIGIT0 = 3'd0,
      STEP_DIGIT1 = 3'd1,
      STEP_DIGIT2 = 3'd2,
      STEP_DIGIT3 = 3'd3,
      STEP_BODY   = 3'd4
   } atfp_step_type;

   typedef struct packed {
      logic              cmd;
      logic [BYTE_W-1:0] rx_byte;
   } atfp_item_type;

   typedef struct packed {
      logic             frame_ok;
      logic [TAG_W-1:0] tag_number;
   } atfp_result_type;

   // decimal weight of the digit taken in a given step
   function automatic logic [TAG_W-1:0] digit_weight(atfp_step_type step);
      logic [TAG_W-1:0] w;
      begin
         unique case (step)
            STEP_DIGIT0: w = 14'd1000;
            STEP_DIGIT1: w = 14'd100;
            STEP_DIGIT2: w = 14'd10;
            STEP_DIGIT3: w = 14'd1;
            default:     w = 14'd0;
         endcase
         return w;
      end
   endfunction

endpackage

@@ sv/atfp_in_stage.sv @@
// Input register for the request stream.
// Depends on atfp_pkg.
module atfp_in_stage
   import atfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  atfp_item_type req_item,
   input  logic          item_take,
   output logic          item_valid,
   output atfp_item_type item
);

   logic          valid_ff, valid_in;
   atfp_item_type item_ff;
   logic          load;

   assign req_tready = !valid_ff || item_take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/atfp_core.sv @@
// Frame parser state and next-state logic: digit hunt, body count, idle timeout.
// Depends on atfp_pkg.
module atfp_core
   import atfp_pkg::*;
#(
   parameter int unsigned FRAME_LEN = 6
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDLE_W-1:0] idle_limit,
   input  logic             item_valid,
   input  atfp_item_type    item,
   input  logic             out_free,
   output logic             item_take,
   output logic             res_valid,
   output atfp_result_type  res
);

   atfp_step_type      step_ff, step_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TAG_W-1:0]   value_ff, value_in;
   logic [BYTE_W-1:0]  last_ff, last_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;

   logic               is_digit;
   logic [DIGIT_W-1:0] digit;
   logic [IDLE_W-1:0]  idle_inc;
   logic [COUNT_W-1:0] count_inc;
   logic               idle_hit;
   logic               frame_done;

   assign is_digit   = (item.rx_byte >= ASCII_ZERO) && (item.rx_byte <= ASCII_NINE);
   assign digit      = DIGIT_W'(item.rx_byte - ASCII_ZERO);
   assign idle_inc   = idle_ff + 1'b1;
   assign idle_hit   = idle_inc >= idle_limit;
   assign count_inc  = count_ff + 1'b1;
   assign frame_done = (item.cmd == CMD_BYTE) && (step_ff == STEP_BODY)
                       && (count_inc >= COUNT_W'(FRAME_LEN));

   assign item_take = item_valid && (!frame_done || out_free);
   assign res_valid = item_take && frame_done;

   // next parse step
   always_comb begin
      step_in = step_ff;
      if (item.cmd == CMD_POLL) begin
         if (idle_hit) begin
            step_in = STEP_DIGIT0;
         end
      end else begin
         unique case (step_ff)
            STEP_DIGIT0: begin
               if (is_digit) step_in = STEP_DIGIT1;
            end
            STEP_DIGIT1: begin
               step_in = is_digit ? STEP_DIGIT2 : STEP_DIGIT0;
            end
            STEP_DIGIT2: begin
               step_in = is_digit ? STEP_DIGIT3 : STEP_DIGIT0;
            end
            STEP_DIGIT3: begin
               step_in = is_digit ? STEP_BODY : STEP_DIGIT0;
            end
            STEP_BODY: begin
               if (frame_done) step_in = STEP_DIGIT0;
            end
            default: begin
               step_in = STEP_DIGIT0;
            end
         endcase
      end
   end

   // datapath and counters
   always_comb begin
      count_in = count_ff;
      value_in = value_ff;
      last_in  = last_ff;
      idle_in  = idle_ff;
      if (item.cmd == CMD_POLL) begin
         if (idle_hit) begin
            idle_in  = '0;
            count_in = '0;
         end else begin
            idle_in = idle_inc;
         end
      end else begin
         idle_in = '0;
         if (step_ff == STEP_BODY) begin
            last_in  = item.rx_byte;
            count_in = frame_done ? '0 : count_inc;
         end else if (is_digit) begin
            if (step_ff == STEP_DIGIT0) begin
               value_in = TAG_W'(digit * digit_weight(step_ff));
            end else begin
               value_in = value_ff + TAG_W'(digit * digit_weight(step_ff));
            end
            count_in = COUNT_W'(step_ff) + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_DIGIT0;
         count_ff <= '0;
         value_ff <= '0;
         last_ff  <= '0;
         idle_ff  <= '0;
      end else if (item_take) begin
         step_ff  <= step_in;
         count_ff <= count_in;
         value_ff <= value_in;
         last_ff  <= last_in;
         idle_ff  <= idle_in;
      end
   end

   assign res.tag_number = value_ff;
   assign res.frame_ok   = (last_ff == ASCII_CR) && (item.rx_byte == ASCII_LF);

endmodule

@@ sv/atfp_out_stage.sv @@
// Result register for the response stream.
// Depends on atfp_pkg.
module atfp_out_stage
   import atfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   input  atfp_result_type res,
   output logic            out_free,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output atfp_result_type rsp_res
);

   logic            valid_ff, valid_in;
   atfp_result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = res_valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

@@ sv/ascii_tag_frame_parser.sv @@
// ASCII tag frame parser, top level: idle limit register, input stage, parser core and result stage.
// Depends on atfp_pkg, atfp_in_stage, atfp_core, atfp_out_stage.
// A request transfer that ends a frame is held in the input register, then the parser update
// loads its result into the result register that drives rsp_tvalid. One transfer per cycle is
// sustained, set by the combinational parser update between the input and result registers;
// a result held by rsp_tready low stalls the next frame-ending byte in the input register.
// Reset: synchronous, clears parser state and stream valids; idle_limit returns to 100.
module ascii_tag_frame_parser
   import atfp_pkg::*;
#(
   parameter int unsigned FRAME_LEN = 6
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        req_tuser,    // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [13:0] tag_number, [14] frame_ok, [15] zero
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [IDLE_W-1:0] idle_limit_ff;
   atfp_item_type     req_item, item;
   atfp_result_type   res, rsp_res;
   logic              item_valid, item_take, res_valid, out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= IDLE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         idle_limit_ff <= csr_wr_data;
      end
   end

   assign req_item.cmd     = req_tuser;
   assign req_item.rx_byte = req_tdata;

   atfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   atfp_core #(
      .FRAME_LEN (FRAME_LEN)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .idle_limit (idle_limit_ff),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .item_take  (item_take),
      .res_valid  (res_valid),
      .res        (res)
   );

   atfp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {1'b0, rsp_res.frame_ok, rsp_res.tag_number};

endmodule

@@ bench/atfp_checker.sv @@
// Scoreboard for the ASCII tag frame parser: follows the request, result and register
// ports, keeps its own copy of the parser state and checks every result transfer.
// Depends on atfp_pkg.
module atfp_checker
   import atfp_pkg::*;
#(
   parameter int unsigned FRAME_LEN = 6
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        req_tuser,    // [0] cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // [13:0] tag_number, [14] frame_ok, [15] zero
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int unsigned fail_count,
   output int unsigned frames_pending
);

   logic [IDLE_W-1:0]  idle_limit;
   atfp_step_type      step;
   logic [COUNT_W-1:0] frame_bytes;
   logic [TAG_W-1:0]   tag_acc;
   logic [BYTE_W-1:0]  prev_body;
   logic [BYTE_W-1:0]  last_body;
   logic [IDLE_W-1:0]  idle_run;
   atfp_result_type    frames_due[$];

   task automatic parse_item(input logic cmd, input logic [BYTE_W-1:0] b);
      logic            is_digit;
      int unsigned     d;
      int unsigned     w;
      atfp_result_type r;
      is_digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
      d = int'(b) - int'(ASCII_ZERO);
      if (cmd == CMD_POLL) begin
         idle_run = idle_run + 16'd1;
         if (idle_run >= idle_limit) begin
            idle_run    = '0;
            step        = STEP_DIGIT0;
            frame_bytes = '0;
         end
      end else begin
         idle_run = '0;
         case (step)
            STEP_DIGIT0: begin
               if (is_digit) begin
                  tag_acc     = TAG_W'(d * 1000);
                  step        = STEP_DIGIT1;
                  frame_bytes = COUNT_W'(1);
               end
            end
            STEP_DIGIT1, STEP_DIGIT2, STEP_DIGIT3: begin
               if (is_digit) begin
                  case (step)
                     STEP_DIGIT1: w = 100;
                     STEP_DIGIT2: w = 10;
                     default:     w = 1;
                  endcase
                  tag_acc     = TAG_W'(int'(tag_acc) + d * w);
                  step        = atfp_step_type'(step + 3'd1);
                  frame_bytes = COUNT_W'(step);
               end else begin
                  step = STEP_DIGIT0;
               end
            end
            default: begin
               prev_body   = last_body;
               last_body   = b;
               frame_bytes = frame_bytes + 7'd1;
               if (int'(frame_bytes) >= int'(FRAME_LEN)) begin
                  r.tag_number = tag_acc;
                  r.frame_ok   = (prev_body == ASCII_CR) && (last_body == ASCII_LF);
                  frames_due.push_back(r);
                  step        = STEP_DIGIT0;
                  frame_bytes = '0;
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      atfp_result_type want;
      atfp_result_type got;
      if (reset) begin
         idle_limit  = IDLE_LIMIT_RESET;
         step        = STEP_DIGIT0;
         frame_bytes = '0;
         tag_acc     = '0;
         prev_body   = '0;
         last_body   = '0;
         idle_run    = '0;
         fail_count  = 0;
         frames_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[TAG_W:0];
            if (frames_due.size() == 0) begin
               $error("unexpected result transfer: tag_number %0d frame_ok %0d",
                      got.tag_number, got.frame_ok);
               fail_count = fail_count + 1;
            end else begin
               want = frames_due.pop_front();
               if (got.tag_number !== want.tag_number) begin
                  $error("tag_number: expected %0d, actual %0d",
                         want.tag_number, got.tag_number);
                  fail_count = fail_count + 1;
               end
               if (got.frame_ok !== want.frame_ok) begin
                  $error("frame_ok: expected %0d, actual %0d", want.frame_ok, got.frame_ok);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (csr_wr_en)
            idle_limit = csr_wr_data;
         if (req_tvalid && req_tready)
            parse_item(req_tuser, req_tdata);
      end
      frames_pending = frames_due.size();
   end

endmodule

@@ bench/testbench.sv @@
// Top of the ASCII tag frame parser bench: clock, reset, byte and poll stimulus,
// result back-pressure, idle limit writes, watchdog and verdict.
// Depends on atfp_pkg, ascii_tag_frame_parser and atfp_checker.
module testbench;
   import atfp_pkg::*;

   localparam int unsigned FRAME_LEN    = 6;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 120;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 78;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata    = '0;
   logic        req_tuser    = CMD_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en    = 1'b0;
   logic [15:0] csr_wr_data  = '0;

   int unsigned fail_count;
   int unsigned frames_pending;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;
   logic        sender_burst = 1'b0;
   logic        hold_off_req = 1'b0;

   always #5 clock = ~clock;

   ascii_tag_frame_parser #(.FRAME_LEN(FRAME_LEN)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   atfp_checker #(.FRAME_LEN(FRAME_LEN)) frame_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .frames_pending (frames_pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int unsigned ready_len();
      if ($urandom_range(0, 99) < 80)
         return $urandom_range(1, 8);
      return $urandom_range(30, 60);
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'(int'(ASCII_ZERO) + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] any_non_digit();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b >= ASCII_ZERO && b <= ASCII_NINE)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // called just after a falling edge; returns just after the falling edge that
   // follows the transfer, with tvalid still high
   task automatic send_item(input logic cmd, input logic [7:0] b);
      int unsigned gap;
      gap = sender_burst ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = b;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent = items_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_item(CMD_BYTE, s[i]);
   endtask

   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (frames_pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idle_limit(input logic [15:0] limit);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_wr_data = limit;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic send_frame();
      int unsigned i;
      int unsigned miss;
      logic        crlf;
      logic [7:0]  b;
      crlf = $urandom_range(0, 9) < 7;
      miss = $urandom_range(0, 2);
      for (i = 0; i < FRAME_LEN; i++) begin
         if ($urandom_range(0, 99) < 6)
            send_item(CMD_POLL, 8'($urandom_range(0, 255)));
         b = 8'($urandom_range(0, 255));
         if (i < 4)
            b = any_digit();
         else if (i == FRAME_LEN - 2 && (crlf || miss == 0))
            b = ASCII_CR;
         else if (i == FRAME_LEN - 1 && (crlf || miss == 1))
            b = ASCII_LF;
         send_item(CMD_BYTE, b);
      end
   endtask

   task automatic send_pattern(input logic [15:0] limit);
      int unsigned pick;
      int unsigned n;
      int unsigned most;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         send_frame();
      end else if (pick < 80) begin
         // digits cut short by a non-digit
         n = $urandom_range(1, 3);
         repeat (n) send_item(CMD_BYTE, any_digit());
         send_item(CMD_BYTE, any_non_digit());
      end else if (pick < 90) begin
         most = (int'(limit) > 15) ? 15 : int'(limit) + 1;
         n = $urandom_range(1, most);
         repeat (n) send_item(CMD_POLL, 8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) send_item(CMD_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   // result side: random ready and stall runs, one long hold-off on request
   initial begin : rsp_drive
      int unsigned left;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
            left = 0;
         end else if (left != 0) begin
            left = left - 1;
         end else if (!rsp_tready) begin
            rsp_tready = 1'b1;
            left = ready_len();
         end else begin
            left = idle_len();
            if (left != 0) begin
               rsp_tready = 1'b0;
               left = left - 1;
            end else begin
               left = ready_len();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_end;
      logic [15:0] limit;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: CR LF frame of zeros, ignored non-digits, restart, poll in body,
      // frame without CR LF, idle drop of a partial frame, then a full CR LF frame
      send_text("0000");
      send_item(CMD_BYTE, ASCII_CR);
      send_item(CMD_BYTE, ASCII_LF);
      send_text("/:");
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, 8'h00);
      send_text("1:");
      send_text("9999");
      send_item(CMD_POLL, 8'hFF);
      send_text("x");
      send_item(CMD_BYTE, ASCII_LF);
      set_idle_limit(16'd2);
      send_text("31");
      send_item(CMD_POLL, 8'h5A);
      send_item(CMD_POLL, 8'h00);
      send_text("2468");
      send_item(CMD_BYTE, ASCII_CR);
      send_item(CMD_BYTE, ASCII_LF);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       limit = 16'd1;
            1:       limit = 16'hFFFF;
            2:       limit = 16'd3;
            3:       limit = 16'($urandom_range(2, 12));
            4:       limit = IDLE_LIMIT_RESET;
            5:       limit = 16'($urandom_range(1, 65535));
            6:       limit = 16'd5;
            default: limit = 16'($urandom_range(1, 20));
         endcase
         set_idle_limit(limit);
         sender_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
         // fill the block while the result side is held off
         if (phase == 2)
            hold_off_req = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end)
            send_pattern(limit);
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/atfp_pkg.sv
sv/atfp_in_stage.sv
sv/atfp_core.sv
sv/atfp_out_stage.sv
sv/ascii_tag_frame_parser.sv
bench/atfp_checker.sv
bench/testbench.sv
